/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the compass heading unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while reset is held.
`define CHU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on clk that also holds across reset.
`define CHU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/chu_pkg.sv */
// Shared constants, types and the arctangent table of the compass heading unit.
package chu_pkg;

  // Number format of the heading.
  localparam int unsigned ANGLE_ITERATIONS = 16;
  localparam int unsigned FRACTION_BITS    = 6;
  localparam int unsigned TABLE_LEN        = 24;
  localparam int unsigned ITER_COUNT       =
    (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;
  localparam int unsigned ITER_W           = $clog2(ITER_COUNT);
  localparam int unsigned TAB_W            = $clog2(TABLE_LEN);

  // Field widths.
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned HEAD_W  = 15;
  localparam int unsigned ANGLE_W = 32;
  // x and y scaled by 2^16, plus room for the CORDIC gain and the sign.
  localparam int unsigned DATA_W  = 36;
  localparam int unsigned SCALE_SH = 16;

  // Full circle in heading units and its width.
  localparam int unsigned FULL_HEADING = 360 << FRACTION_BITS;
  localparam int unsigned FULL_W       = $clog2(FULL_HEADING + 1);
  localparam int unsigned PROD_W       = ANGLE_W + FULL_W;

  // Largest heading the output can carry.
  localparam int unsigned HEAD_MAX =
    (FULL_HEADING - 1 < (1 << HEAD_W)) ? FULL_HEADING - 1 : (1 << HEAD_W) - 1;

  // Binary angle of a half turn.
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // Mode codes.
  localparam logic MODE_INIT = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROT   = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_DONE  = 4'b1000
  } chu_state_t;

  // Status of a multi-cycle unit toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } chu_stat_t;

  // atan(2^-i) as a fraction of a full turn, times 2^32.
  function automatic logic [ANGLE_W-1:0] atan_turn(input logic [TAB_W-1:0] idx);
    logic [ANGLE_W-1:0] a;
    unique case (idx)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2F9;
      5'd15: a = 32'h0000_517C;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A2F;
      5'd19: a = 32'h0000_0517;
      5'd20: a = 32'h0000_028B;
      5'd21: a = 32'h0000_0145;
      5'd22: a = 32'h0000_00A2;
      5'd23: a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* sv/chu_cordic.sv */
// Iterative CORDIC vectoring unit: one shared shift-add micro-rotation per cycle.
module chu_cordic import chu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [RAW_W-1:0]   x_in,
  input  logic signed [RAW_W-1:0]   y_in,
  output logic [ANGLE_W-1:0]        angle,
  output chu_stat_t                 stat
);

  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] y_r, y_nxt;
  logic [ANGLE_W-1:0]       z_r, z_nxt;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  logic signed [DATA_W-1:0] x_ext, y_ext;
  logic signed [DATA_W-1:0] dx, dy;
  logic [ANGLE_W-1:0]       step_ang;

  // Scale inputs by 2^16.
  assign x_ext = {{(DATA_W-RAW_W){x_in[RAW_W-1]}}, x_in} <<< SCALE_SH;
  assign y_ext = {{(DATA_W-RAW_W){y_in[RAW_W-1]}}, y_in} <<< SCALE_SH;

  // Shared shifter and table lookup for the current step.
  assign dx       = y_r >>> cnt_r;
  assign dy       = x_r >>> cnt_r;
  assign step_ang = atan_turn(TAB_W'(cnt_r));

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // Left half plane: pre-rotate by a half turn.
      if (x_in < 0) begin
        x_nxt = -x_ext;
        y_nxt = -y_ext;
        z_nxt = HALF_TURN;
      end else begin
        x_nxt = x_ext;
        y_nxt = y_ext;
        z_nxt = '0;
      end
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Rotate toward the positive x axis.
      if (y_r > 0) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + step_ang;
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - step_ang;
      end
      if (cnt_r == ITER_W'(ITER_COUNT - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign angle     = z_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

/* sv/chu_scale.sv */
// Binary angle to heading conversion: registered multiply, then round and wrap.
module chu_scale import chu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [ANGLE_W-1:0] angle,
  output logic [HEAD_W-1:0]  heading,
  output chu_stat_t          stat
);

  localparam logic [FULL_W-1:0]  FULL_C  = FULL_W'(FULL_HEADING);
  localparam logic [PROD_W:0]    ROUND_C = (PROD_W + 1)'(64'h8000_0000);

  logic [PROD_W-1:0] prod_r;
  logic              mul_vld_r;
  logic              done_r;
  logic [HEAD_W-1:0] head_r;

  logic [PROD_W:0]   rsum;
  logic [FULL_W:0]   h_round;
  logic [HEAD_W-1:0] h_wrap;

  // Round to nearest, wrap a full circle to zero.
  assign rsum    = {1'b0, prod_r} + ROUND_C;
  assign h_round = rsum[PROD_W:ANGLE_W];
  assign h_wrap  = (h_round >= (FULL_W + 1)'(FULL_HEADING)) ? '0 : HEAD_W'(h_round);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      mul_vld_r <= start;
      done_r    <= mul_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(angle) * PROD_W'(FULL_C);
    end
    if (mul_vld_r) begin
      head_r <= h_wrap;
    end
  end

  assign heading   = head_r;
  assign stat.busy = mul_vld_r;
  assign stat.done = done_r;

endmodule

/* sv/compass_heading_unit.sv */
// Top level of the compass heading unit: sequencer, mode and heading state, result register.
// One transfer per sensor tick. A tick in init mode only applies init_ok. It passes through
// ST_DONE, where its result is loaded into the output register, and the input is free again
// once the sequencer is back in ST_IDLE. A zero vector in running mode skips the loop and
// takes the same path. Any other running tick passes through ST_ROT, where chu_cordic does
// ITER_COUNT micro-rotations, one per cycle, then ST_SCALE, where chu_scale multiplies,
// rounds and wraps, and the heading is stored; its result is then loaded in ST_DONE. The
// input is free again once the sequencer is back in ST_IDLE. in_stall is high while a tick
// is in work. A finished result waits in the output register, and the next tick is taken
// while it waits. A second finished result waits in the sequencer until the first one
// leaves. No internal memory, no clearing pass after reset.
module compass_heading_unit import chu_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [RAW_W-1:0] in_raw_x,
  input  logic signed [RAW_W-1:0] in_raw_y,
  input  logic                    in_read_ok,
  input  logic                    in_init_ok,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HEAD_W-1:0]       out_heading,
  output logic                    out_module_state
);

  chu_state_t        state_r, state_nxt;
  logic              mode_r, mode_nxt;
  logic [HEAD_W-1:0] heading_r, heading_nxt;
  logic              read_ok_r, read_ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [HEAD_W-1:0] out_heading_r;
  logic              out_mode_r;

  logic              in_xfer;
  logic              out_free;
  logic              load_out;
  logic              cordic_start;
  logic              scale_start;
  logic [ANGLE_W-1:0] angle;
  logic [HEAD_W-1:0] scaled_heading;
  chu_stat_t         cordic_stat;
  chu_stat_t         scale_stat;

  assign in_stall = !rst_n || (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  chu_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (in_raw_x),
    .y_in  (in_raw_y),
    .angle (angle),
    .stat  (cordic_stat)
  );

  chu_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (scale_start),
    .angle   (angle),
    .heading (scaled_heading),
    .stat    (scale_stat)
  );

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    heading_nxt  = heading_r;
    read_ok_nxt  = read_ok_r;
    cordic_start = 1'b0;
    scale_start  = 1'b0;
    load_out     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (mode_r == MODE_INIT) begin
            mode_nxt  = in_init_ok ? MODE_RUN : MODE_INIT;
            state_nxt = ST_DONE;
          end else if (in_raw_x == '0 && in_raw_y == '0) begin
            // Zero vector reads as heading zero.
            heading_nxt = '0;
            mode_nxt    = in_read_ok ? MODE_RUN : MODE_INIT;
            state_nxt   = ST_DONE;
          end else begin
            read_ok_nxt  = in_read_ok;
            cordic_start = 1'b1;
            state_nxt    = ST_ROT;
          end
        end
      end
      ST_ROT: begin
        if (cordic_stat.done) begin
          scale_start = 1'b1;
          state_nxt   = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_stat.done) begin
          heading_nxt = scaled_heading;
          mode_nxt    = read_ok_r ? MODE_RUN : MODE_INIT;
          state_nxt   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register handshake.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_INIT;
      heading_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      heading_r   <= heading_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    read_ok_r <= read_ok_nxt;
    if (load_out) begin
      out_heading_r <= heading_r;
      out_mode_r    <= mode_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_heading      = out_heading_r;
  assign out_module_state = out_mode_r;

endmodule

/* sv/chu_checker.sv */
// Port-level checks of the compass heading unit and their bind to the top level.
`include "assert_macros.svh"

module chu_checker import chu_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [HEAD_W-1:0] out_heading,
  input logic              out_module_state
);

  // A stalled result holds.
  `CHU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_heading) && $stable(out_module_state), "stalled result changed")

  // Heading stays within one circle.
  `CHU_ASSERT(a_head_range, out_valid |-> out_heading <= HEAD_W'(HEAD_MAX), "heading out of range")

  // A taken tick keeps the input side busy in the next cycle.
  `CHU_ASSERT(a_busy_after_xfer, in_valid && !in_stall |=> in_stall, "input taken while a tick is in work")

  // Reset clears the result channel.
  `CHU_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid && in_stall == !rst_n || rst_n, "result valid after reset")

endmodule

bind compass_heading_unit chu_checker u_chu_checker (.*);
